### rtl/core/bds_pkg.sv
// Shared types and constants for the 2x2 box downsampler.
// Used by box_downsample_2x2 and bds_line_buf; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_W        = 11;
    localparam int SUM_W        = 9;
    localparam int TOT_W        = 10;
    localparam int CFG_IDX_W    = 1;
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;
    localparam int RESET_COLS   = 640;
    localparam int RESET_ROWS   = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_COLS = 1'b0,
        REG_IMAGE_ROWS = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

### rtl/core/bds_line_buf.sv
// Line buffer holding the horizontal pair sums of the latest even row.
// One write port and one registered read port; depends on bds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bds_line_buf #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire [ADDR_W-1:0]          wr_addr,
    input  wire [bds_pkg::SUM_W-1:0]  wr_data,
    input  wire                       rd_en,
    input  wire [ADDR_W-1:0]          rd_addr,
    output logic [bds_pkg::SUM_W-1:0] rd_data
);
    import bds_pkg::*;

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/box_downsample_2x2.sv
// 2x2 box downsampler for 8-bit grey frames, top level.
// Depends on bds_pkg and bds_line_buf.
//
// Pixels enter in raster order on the s_ channel, one per transaction. Each
// output pixel on the m_ channel is the rounded average (sum + 2) >> 2 of one
// aligned 2x2 block; an odd last column or odd last row is dropped. The last
// output of a frame carries m_frame_last. Frame width and height are written
// through cfg_ (index 0 width, index 1 height) by the user only while the block
// is idle, which the block does not enforce; zero acts as one, above max as max.
//
// Throughput is one pixel per cycle while the receiver keeps up. A result is
// presented in the cycle after the transaction that completes its block. The
// pair sums of each even row live in a single-port-write, registered-read line
// buffer; the read for a block is issued on its even-column pixel, so the
// odd-column pixel finds the data waiting. A pixel that completes a block is
// accepted only when the output register is empty or is being emptied; other
// pixels keep flowing while a result waits, so a stalled receiver holds the
// input at the next completing pixel. Reset clears the counters and the output
// valid flag and restores 640x480; the line buffer needs no clearing because
// each even row writes it first.
`timescale 1ns / 1ps
`default_nettype none

module box_downsample_2x2 #(
    parameter int MAX_COLS = bds_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = bds_pkg::DEF_MAX_ROWS
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [bds_pkg::CFG_W-1:0]      cfg_data,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire [bds_pkg::PIX_W-1:0]      s_pixel_in,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [bds_pkg::PIX_W-1:0]     m_pixel_out,
    output logic                          m_frame_last
);
    import bds_pkg::*;

    localparam int LINE_DEPTH = (MAX_COLS / 2 > 0) ? MAX_COLS / 2 : 1;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CCNT_W     = $clog2(MAX_COLS) + 1;
    localparam int RCNT_W     = $clog2(MAX_ROWS) + 1;
    localparam int CCMP_W     = (CCNT_W + 1 > CFG_W) ? CCNT_W + 1 : CFG_W;
    localparam int RCMP_W     = (RCNT_W + 1 > CFG_W) ? RCNT_W + 1 : CFG_W;
    localparam int COLS_RST   = (RESET_COLS > MAX_COLS) ? MAX_COLS : RESET_COLS;
    localparam int ROWS_RST   = (RESET_ROWS > MAX_ROWS) ? MAX_ROWS : RESET_ROWS;

    logic [CCMP_W-1:0] cols_reg, cols_next;
    logic [RCMP_W-1:0] rows_reg, rows_next;
    logic [CCNT_W-1:0] col_count_reg, col_count_next;
    logic [RCNT_W-1:0] row_count_reg, row_count_next;
    logic [PIX_W-1:0]  pair_sum_reg, pair_sum_next;
    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  pixel_out_reg, pixel_out_next;
    logic              frame_last_reg, frame_last_next;

    logic              s_fire;
    logic              cfg_fire;
    logic [CFG_W-1:0]  cfg_nz;
    logic [CCNT_W-2:0] slot_raw;
    logic [ADDR_W-1:0] slot;
    logic              col_odd;
    logic              row_odd;
    logic              result_due;
    logic [SUM_W-1:0]  pair_total;
    logic [SUM_W-1:0]  line_rd_data;
    logic [TOT_W-1:0]  block_sum;
    logic [CCMP_W-1:0] last_col;
    logic [RCMP_W-1:0] last_row;
    logic              is_last;
    logic              col_wrap;
    logic              row_wrap;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid & cfg_ready;
    assign result_due = col_odd & row_odd;
    assign s_ready    = ~result_due | ~m_valid_reg | m_ready;
    assign s_fire     = s_valid & s_ready;

    assign col_odd    = col_count_reg[0];
    assign row_odd    = row_count_reg[0];
    assign slot_raw   = col_count_reg[CCNT_W-1:1];
    assign slot       = (slot_raw >= (CCNT_W-1)'(LINE_DEPTH)) ? '0 : slot_raw[ADDR_W-1:0];
    assign pair_total = SUM_W'(pair_sum_reg) + SUM_W'(s_pixel_in);
    assign block_sum  = TOT_W'(line_rd_data) + TOT_W'(pair_total) + TOT_W'(2);

    assign last_col = {cols_reg[CCMP_W-1:1], 1'b0} - CCMP_W'(1);
    assign last_row = {rows_reg[RCMP_W-1:1], 1'b0} - RCMP_W'(1);
    assign is_last  = (cols_reg >= CCMP_W'(2)) && (rows_reg >= RCMP_W'(2)) &&
                      (CCMP_W'(col_count_reg) == last_col) &&
                      (RCMP_W'(row_count_reg) == last_row);
    assign col_wrap = (CCMP_W'(col_count_reg) + CCMP_W'(1)) >= cols_reg;
    assign row_wrap = (RCMP_W'(row_count_reg) + RCMP_W'(1)) >= rows_reg;

    bds_line_buf #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (s_fire & col_odd & ~row_odd),
        .wr_addr (slot),
        .wr_data (pair_total),
        .rd_en   (s_fire & ~col_odd),
        .rd_addr (slot),
        .rd_data (line_rd_data)
    );

    assign cfg_nz = (cfg_data == '0) ? CFG_W'(1) : cfg_data;

    always_comb begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_fire) begin
            case (cfg_index)
                REG_IMAGE_COLS: begin
                    cols_next = (CCMP_W'(cfg_nz) > CCMP_W'(MAX_COLS)) ?
                                CCMP_W'(MAX_COLS) : CCMP_W'(cfg_nz);
                end
                REG_IMAGE_ROWS: begin
                    rows_next = (RCMP_W'(cfg_nz) > RCMP_W'(MAX_ROWS)) ?
                                RCMP_W'(MAX_ROWS) : RCMP_W'(cfg_nz);
                end
                default: begin
                    cols_next = cols_reg;
                end
            endcase
        end
    end

    always_comb begin
        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        pair_sum_next   = pair_sum_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        pixel_out_next  = pixel_out_reg;
        frame_last_next = frame_last_reg;
        if (s_fire) begin
            if (!col_odd) begin
                pair_sum_next = s_pixel_in;
            end else if (row_odd) begin
                m_valid_next    = 1'b1;
                pixel_out_next  = block_sum[PIX_W+1:2];
                frame_last_next = is_last;
            end
            if (col_wrap) begin
                col_count_next = '0;
                row_count_next = row_wrap ? '0 : row_count_reg + RCNT_W'(1);
            end else begin
                col_count_next = col_count_reg + CCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg      <= CCMP_W'(COLS_RST);
            rows_reg      <= RCMP_W'(ROWS_RST);
            col_count_reg <= '0;
            row_count_reg <= '0;
            pair_sum_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            pair_sum_reg  <= pair_sum_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pixel_out_reg  <= pixel_out_next;
        frame_last_reg <= frame_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = pixel_out_reg;
    assign m_frame_last = frame_last_reg;

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the 2x2 box downsampler box_downsample_2x2.
// Streams frames through the valid/ready channels with random idling and checks
// every output pixel against a predictor in this file; depends on bds_pkg.
`timescale 1ns / 1ps

module tb_top;
    import bds_pkg::*;

    localparam int LINE_SLOTS = DEF_MAX_COLS / 2;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } block_avg_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    cfg_reg_t         cfg_index = REG_IMAGE_COLS;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [PIX_W-1:0] s_pixel_in = '0;
    logic             m_valid;
    logic             m_ready = 1'b1;
    logic [PIX_W-1:0] m_pixel_out;
    logic             m_frame_last;

    block_avg_t       pending_avgs[$];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [SUM_W-1:0] line_sums[LINE_SLOTS];
    logic [SUM_W-1:0] even_pixel;
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      mismatch_count = 0;
    int unsigned      pixels_accepted = 0;
    int unsigned      averages_checked = 0;
    int unsigned      frames_sent = 0;
    int unsigned      burst_left = 0;
    int unsigned      stall_mode = 0;
    int unsigned      stall_left = 0;

    box_downsample_2x2 uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_frame_last (m_frame_last)
    );

    always #6 aclk = ~aclk;

    function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned lim);
        if (v == 0) begin
            return 1;
        end
        if (v > lim) begin
            return lim;
        end
        return 32'(v);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Advances the predicted block state by one pixel and queues any average it completes.
    task automatic downsample_pixel(input logic [PIX_W-1:0] pix);
        int unsigned      cols;
        int unsigned      rows;
        int unsigned      slot;
        int unsigned      total;
        logic [SUM_W-1:0] pair;
        block_avg_t       avg;
        cols = eff_size(width_reg, DEF_MAX_COLS);
        rows = eff_size(height_reg, DEF_MAX_ROWS);
        slot = (col_pos / 2) % LINE_SLOTS;
        if (col_pos % 2 == 0) begin
            even_pixel = SUM_W'(pix);
        end else begin
            pair = even_pixel + SUM_W'(pix);
            if (row_pos % 2 == 0) begin
                line_sums[slot] = pair;
            end else begin
                total = line_sums[slot] + pair;
                avg.pixel = PIX_W'((total + 2) >> 2);
                avg.last = (cols >= 2) && (rows >= 2) &&
                           (col_pos == (cols & ~1) - 1) && (row_pos == (rows & ~1) - 1);
                pending_avgs.push_back(avg);
            end
        end
        if (col_pos + 1 >= cols) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    always @(posedge aclk) begin
        block_avg_t want;
        if (!aresetn) begin
            width_reg = CFG_W'(RESET_COLS);
            height_reg = CFG_W'(RESET_ROWS);
            even_pixel = '0;
            col_pos = 0;
            row_pos = 0;
            pending_avgs.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_avgs.size() == 0) begin
                    report_mismatch($sformatf("unexpected output pixel %0d last %0b",
                                              m_pixel_out, m_frame_last));
                end else begin
                    want = pending_avgs.pop_front();
                    averages_checked++;
                    if (m_pixel_out !== want.pixel) begin
                        report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                                  m_pixel_out, want.pixel));
                    end
                    if (m_frame_last !== want.last) begin
                        report_mismatch($sformatf("frame_last %0b, expected %0b",
                                                  m_frame_last, want.last));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_IMAGE_COLS) begin
                    width_reg = cfg_data;
                end else begin
                    height_reg = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                pixels_accepted++;
                downsample_pixel(s_pixel_in);
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int unsigned gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 32);
        end
        s_valid <= 1'b1;
        s_pixel_in <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_avgs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_size(input int unsigned cols, input int unsigned rows);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= REG_IMAGE_COLS;
        cfg_data <= CFG_W'(cols);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= REG_IMAGE_ROWS;
        cfg_data <= CFG_W'(rows);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // A negative fill sends random pixels.
    task automatic run_frame(input int unsigned cols, input int unsigned rows, input int fill);
        int unsigned n;
        n = eff_size(CFG_W'(cols), DEF_MAX_COLS) * eff_size(CFG_W'(rows), DEF_MAX_ROWS);
        set_size(cols, rows);
        repeat (n) send_pixel(fill < 0 ? PIX_W'($urandom_range(0, 255)) : PIX_W'(fill));
        frames_sent++;
    endtask

    task automatic test_reset_size();
        repeat (2 * RESET_COLS) send_pixel(PIX_W'($urandom_range(0, 255)));
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= REG_IMAGE_COLS;
        cfg_data <= CFG_W'(2);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        repeat (2 * (RESET_ROWS - 2)) send_pixel(PIX_W'($urandom_range(0, 255)));
        frames_sent++;
    endtask

    task automatic test_pixel_extremes();
        run_frame(2, 2, 255);
        run_frame(2, 2, 0);
    endtask

    task automatic test_rounding();
        logic [PIX_W-1:0] top_row[8] = '{0, 1, 1, 1, 2, 2, 255, 255};
        logic [PIX_W-1:0] bottom_row[8] = '{0, 0, 1, 0, 1, 1, 255, 254};
        set_size(8, 2);
        foreach (top_row[i]) send_pixel(top_row[i]);
        foreach (bottom_row[i]) send_pixel(bottom_row[i]);
        frames_sent++;
    endtask

    task automatic test_odd_and_unit_sizes();
        run_frame(3, 3, -1);
        run_frame(5, 4, -1);
        run_frame(1, 3, -1);
        run_frame(4, 1, -1);
        run_frame(0, 0, -1);
        run_frame(3, 0, -1);
    endtask

    task automatic test_size_clamp();
        run_frame(2047, 2, -1);
        run_frame(2, 1025, -1);
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned cols;
        int unsigned rows;
        int unsigned n;
        bit          paused;
        sent = 0;
        paused = 1'b0;
        while (sent < 450) begin
            cols = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
            rows = $urandom_range(0, 9);
            n = eff_size(CFG_W'(cols), DEF_MAX_COLS) * eff_size(CFG_W'(rows), DEF_MAX_ROWS);
            set_size(cols, rows);
            for (int i = 0; i < n; i++) begin
                if (!paused && n >= 16 && i == n / 2) begin
                    settle_block();
                    paused = 1'b1;
                end
                send_pixel(PIX_W'($urandom_range(0, 255)));
            end
            sent += n;
            frames_sent++;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_size();
        test_pixel_extremes();
        test_rounding();
        test_odd_and_unit_sizes();
        test_size_clamp();
        test_random_frames();
        settle_block();
        repeat (16) @(posedge aclk);
        $display("Covered %0d frames: %0d pixels in, %0d averages checked.",
                 frames_sent, pixels_accepted, averages_checked);
        $display("Sizes ranged from 1x1 up to the clamped maximum, with random stalls.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out waiting for the block.");
        $display("Mismatches found");
        $finish;
    end

endmodule
